FILE: hw/rtl/bnms_pkg.sv
// ----------------------------------------------------------------------------
// bnms_pkg: shared types and constants
// Controller states, the command and status bundles between the controller
// and the datapath, and the register map of the configuration port.
// ----------------------------------------------------------------------------
package bnms_pkg;

  localparam logic [15:0] IOU_THRESHOLD_RESET = 16'd19661;
  localparam logic        REG_IOU_THRESHOLD   = 1'b0;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_S_RD_I,
    ST_S_LAT_I,
    ST_S_RD_J,
    ST_S_CMP,
    ST_S_WR,
    ST_N_RD_RI,
    ST_N_LAT_I,
    ST_N_CHK_I,
    ST_N_LAT_A,
    ST_N_RD_RJ,
    ST_N_LAT_J,
    ST_N_CHK_J,
    ST_N_LAT_B,
    ST_N_C1,
    ST_N_C2,
    ST_N_C3,
    ST_N_C4,
    ST_N_MARK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load;       // store the incoming box
    logic use_j;      // read addresses come from the inner counter and inner index
    logic use_idx;    // score read address comes from the outer box index
    logic i_clr;
    logic i_inc;
    logic j_clr;
    logic j_set;      // inner counter starts one past the outer one
    logic j_inc;
    logic lat_si;     // capture the outer score for ranking
    logic cmp;        // rank compare step
    logic wr_rank;
    logic lat_idx_i;
    logic lat_idx_j;
    logic lat_a;      // capture the surviving box, emit the previous one
    logic lat_b;
    logic mark;       // suppress the inner box on too much overlap
    logic flush;      // emit the last survivor and clear batch state
  } cmd_t;

  typedef struct packed {
    logic i_last;
    logic j_last;
    logic flag_i;
    logic flag_j;
  } stat_t;

endpackage

FILE: hw/rtl/bnms_ram.sv
// ----------------------------------------------------------------------------
// bnms_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module bnms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/bnms_ctrl.sv
// ----------------------------------------------------------------------------
// bnms_ctrl: batch sequencer
// Steps through loading, ranking, pairwise suppression and the final flush.
// ----------------------------------------------------------------------------
module bnms_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            final_box,
  input  bnms_pkg::stat_t stat,
  output bnms_pkg::cmd_t  cmd,
  output logic            busy
);

  bnms_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bnms_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bnms_pkg::ST_IDLE:    if (start && final_box) state_nxt = bnms_pkg::ST_S_RD_I;
      bnms_pkg::ST_S_RD_I:  state_nxt = bnms_pkg::ST_S_LAT_I;
      bnms_pkg::ST_S_LAT_I: state_nxt = bnms_pkg::ST_S_RD_J;
      bnms_pkg::ST_S_RD_J:  state_nxt = bnms_pkg::ST_S_CMP;
      bnms_pkg::ST_S_CMP:
        state_nxt = stat.j_last ? bnms_pkg::ST_S_WR : bnms_pkg::ST_S_RD_J;
      bnms_pkg::ST_S_WR:
        state_nxt = stat.i_last ? bnms_pkg::ST_N_RD_RI : bnms_pkg::ST_S_RD_I;
      bnms_pkg::ST_N_RD_RI: state_nxt = bnms_pkg::ST_N_LAT_I;
      bnms_pkg::ST_N_LAT_I: state_nxt = bnms_pkg::ST_N_CHK_I;
      bnms_pkg::ST_N_CHK_I: begin
        if (!stat.flag_i) state_nxt = bnms_pkg::ST_N_LAT_A;
        else if (stat.i_last) state_nxt = bnms_pkg::ST_FLUSH;
        else state_nxt = bnms_pkg::ST_N_RD_RI;
      end
      bnms_pkg::ST_N_LAT_A:
        state_nxt = stat.i_last ? bnms_pkg::ST_FLUSH : bnms_pkg::ST_N_RD_RJ;
      bnms_pkg::ST_N_RD_RJ: state_nxt = bnms_pkg::ST_N_LAT_J;
      bnms_pkg::ST_N_LAT_J: state_nxt = bnms_pkg::ST_N_CHK_J;
      bnms_pkg::ST_N_CHK_J: begin
        if (!stat.flag_j) state_nxt = bnms_pkg::ST_N_LAT_B;
        else if (!stat.j_last) state_nxt = bnms_pkg::ST_N_RD_RJ;
        else state_nxt = stat.i_last ? bnms_pkg::ST_FLUSH : bnms_pkg::ST_N_RD_RI;
      end
      bnms_pkg::ST_N_LAT_B: state_nxt = bnms_pkg::ST_N_C1;
      bnms_pkg::ST_N_C1:    state_nxt = bnms_pkg::ST_N_C2;
      bnms_pkg::ST_N_C2:    state_nxt = bnms_pkg::ST_N_C3;
      bnms_pkg::ST_N_C3:    state_nxt = bnms_pkg::ST_N_C4;
      bnms_pkg::ST_N_C4:    state_nxt = bnms_pkg::ST_N_MARK;
      bnms_pkg::ST_N_MARK: begin
        if (!stat.j_last) state_nxt = bnms_pkg::ST_N_RD_RJ;
        else state_nxt = stat.i_last ? bnms_pkg::ST_FLUSH : bnms_pkg::ST_N_RD_RI;
      end
      bnms_pkg::ST_FLUSH:   state_nxt = bnms_pkg::ST_IDLE;
      default:              state_nxt = bnms_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      bnms_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
        cmd.i_clr = 1'b1;
      end
      bnms_pkg::ST_S_RD_I: ;
      bnms_pkg::ST_S_LAT_I: begin
        cmd.lat_si = 1'b1;
        cmd.j_clr  = 1'b1;
      end
      bnms_pkg::ST_S_RD_J: cmd.use_j = 1'b1;
      bnms_pkg::ST_S_CMP: begin
        cmd.cmp   = 1'b1;
        cmd.j_inc = 1'b1;
      end
      bnms_pkg::ST_S_WR: begin
        cmd.wr_rank = 1'b1;
        if (stat.i_last) cmd.i_clr = 1'b1;
        else cmd.i_inc = 1'b1;
      end
      bnms_pkg::ST_N_RD_RI: ;
      bnms_pkg::ST_N_LAT_I: cmd.lat_idx_i = 1'b1;
      bnms_pkg::ST_N_CHK_I: begin
        cmd.use_idx = 1'b1;
        if (stat.flag_i) cmd.i_inc = 1'b1;
      end
      bnms_pkg::ST_N_LAT_A: begin
        cmd.lat_a = 1'b1;
        cmd.j_set = 1'b1;
      end
      bnms_pkg::ST_N_RD_RJ: cmd.use_j = 1'b1;
      bnms_pkg::ST_N_LAT_J: cmd.lat_idx_j = 1'b1;
      bnms_pkg::ST_N_CHK_J: begin
        cmd.use_j = 1'b1;
        if (stat.flag_j) begin
          if (stat.j_last) cmd.i_inc = 1'b1;
          else cmd.j_inc = 1'b1;
        end
      end
      bnms_pkg::ST_N_LAT_B: cmd.lat_b = 1'b1;
      bnms_pkg::ST_N_C1, bnms_pkg::ST_N_C2, bnms_pkg::ST_N_C3, bnms_pkg::ST_N_C4: ;
      bnms_pkg::ST_N_MARK: begin
        cmd.mark = 1'b1;
        if (stat.j_last) cmd.i_inc = 1'b1;
        else cmd.j_inc = 1'b1;
      end
      bnms_pkg::ST_FLUSH: cmd.flush = 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/bnms_datapath.sv
// ----------------------------------------------------------------------------
// bnms_datapath: box storage, ranking and overlap arithmetic
// Holds the box, score and rank memories, the loop counters, the suppressed
// flags, the four-stage overlap test and the result registers.
// ----------------------------------------------------------------------------
module bnms_datapath #(
  parameter int MAX_BOXES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bnms_pkg::cmd_t     cmd,
  output bnms_pkg::stat_t    stat,
  input  logic        [15:0] iou_threshold,
  input  logic signed [15:0] in_left,
  input  logic signed [15:0] in_top,
  input  logic signed [15:0] in_right,
  input  logic signed [15:0] in_bottom,
  input  logic        [15:0] in_confidence,
  output logic               out_valid,
  output logic signed [15:0] out_kept_left,
  output logic signed [15:0] out_kept_top,
  output logic signed [15:0] out_kept_right,
  output logic signed [15:0] out_kept_bottom,
  output logic        [15:0] out_kept_confidence,
  output logic               out_overflowed,
  output logic               out_final_kept
);

  localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);

  logic [CW-1:0] count_r, i_r, j_r, pos_r;
  logic          ovf_r;
  logic [15:0]   score_i_r, score_a_r;
  logic [IW-1:0] idx_i_r, idx_j_r;
  logic [63:0]   box_a_r, box_b_r;
  logic [MAX_BOXES-1:0] flags_r;
  logic          pend_r;

  logic [63:0]   box_q;
  logic [15:0]   score_q;
  logic [IW-1:0] rank_q;
  logic [IW-1:0] score_raddr, box_raddr, rank_raddr;
  logic          store_we;

  assign store_we = cmd.load && (count_r < CW'(MAX_BOXES));
  assign score_raddr = cmd.use_idx ? idx_i_r : (cmd.use_j ? j_r[IW-1:0] : i_r[IW-1:0]);
  assign box_raddr   = cmd.use_j ? idx_j_r : idx_i_r;
  assign rank_raddr  = cmd.use_j ? j_r[IW-1:0] : i_r[IW-1:0];

  bnms_ram #(.WIDTH(64), .DEPTH(MAX_BOXES)) u_box_ram (
    .clk(clk), .we(store_we), .waddr(count_r[IW-1:0]),
    .wdata({in_bottom, in_right, in_top, in_left}),
    .raddr(box_raddr), .rdata(box_q)
  );

  bnms_ram #(.WIDTH(16), .DEPTH(MAX_BOXES)) u_score_ram (
    .clk(clk), .we(store_we), .waddr(count_r[IW-1:0]), .wdata(in_confidence),
    .raddr(score_raddr), .rdata(score_q)
  );

  bnms_ram #(.WIDTH(IW), .DEPTH(MAX_BOXES)) u_rank_ram (
    .clk(clk), .we(cmd.wr_rank), .waddr(pos_r[IW-1:0]), .wdata(i_r[IW-1:0]),
    .raddr(rank_raddr), .rdata(rank_q)
  );

  assign stat.i_last = (i_r + CW'(1)) == count_r;
  assign stat.j_last = (j_r + CW'(1)) == count_r;
  assign stat.flag_i = flags_r[idx_i_r];
  assign stat.flag_j = flags_r[idx_j_r];

  // Overlap test pipeline; every stage is registered.
  logic signed [15:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
  logic signed [16:0] dx, dy;
  logic        [15:0] s1_iw_r, s1_ih_r;
  logic signed [16:0] s1_wa_r, s1_ha_r, s1_wb_r, s1_hb_r;
  logic        [31:0] s2_inter_r;
  logic signed [33:0] s2_area_a_r, s2_area_b_r;
  logic        [31:0] s3_inter_r;
  logic signed [35:0] s3_uni_r;
  logic        [50:0] s4_prod_r, s4_lhs_r;
  logic               s4_upos_r;
  logic               too_much;

  assign ax1 = box_a_r[15:0];
  assign ay1 = box_a_r[31:16];
  assign ax2 = box_a_r[47:32];
  assign ay2 = box_a_r[63:48];
  assign bx1 = box_b_r[15:0];
  assign by1 = box_b_r[31:16];
  assign bx2 = box_b_r[47:32];
  assign by2 = box_b_r[63:48];

  assign dx = 17'((ax2 < bx2) ? ax2 : bx2) - 17'((ax1 > bx1) ? ax1 : bx1);
  assign dy = 17'((ay2 < by2) ? ay2 : by2) - 17'((ay1 > by1) ? ay1 : by1);

  always_ff @(posedge clk) begin
    s1_iw_r     <= dx[16] ? 16'd0 : dx[15:0];
    s1_ih_r     <= dy[16] ? 16'd0 : dy[15:0];
    s1_wa_r     <= 17'(ax2) - 17'(ax1);
    s1_ha_r     <= 17'(ay2) - 17'(ay1);
    s1_wb_r     <= 17'(bx2) - 17'(bx1);
    s1_hb_r     <= 17'(by2) - 17'(by1);
    s2_inter_r  <= s1_iw_r * s1_ih_r;
    s2_area_a_r <= s1_wa_r * s1_ha_r;
    s2_area_b_r <= s1_wb_r * s1_hb_r;
    s3_inter_r  <= s2_inter_r;
    s3_uni_r    <= 36'(s2_area_a_r) + 36'(s2_area_b_r) - 36'({1'b0, s2_inter_r});
    s4_upos_r   <= !s3_uni_r[35] && (s3_uni_r != '0);
    s4_prod_r   <= iou_threshold * s3_uni_r[34:0];
    s4_lhs_r    <= {3'b000, s3_inter_r, 16'h0000};
  end

  assign too_much = s4_upos_r && (s4_lhs_r > s4_prod_r);

  // Counters and batch state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      ovf_r     <= 1'b0;
      i_r       <= '0;
      j_r       <= '0;
      pos_r     <= '0;
      flags_r   <= '0;
      pend_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // A survivor goes out when the next one is captured, and the last one
      // goes out on the flush.
      out_valid <= (cmd.lat_a && pend_r) || cmd.flush;
      if (cmd.load) begin
        if (store_we) count_r <= count_r + CW'(1);
        else ovf_r <= 1'b1;
      end
      if (cmd.i_clr) i_r <= '0;
      else if (cmd.i_inc) i_r <= i_r + CW'(1);
      if (cmd.j_clr) j_r <= '0;
      else if (cmd.j_set) j_r <= i_r + CW'(1);
      else if (cmd.j_inc) j_r <= j_r + CW'(1);
      if (cmd.lat_si) pos_r <= '0;
      else if (cmd.cmp && ((score_q > score_i_r) ||
                           ((score_q == score_i_r) && (j_r < i_r)))) begin
        pos_r <= pos_r + CW'(1);
      end
      if (cmd.mark && too_much) flags_r[idx_j_r] <= 1'b1;
      if (cmd.lat_a) begin
        pend_r    <= 1'b1;
      end
      if (cmd.flush) begin
        pend_r    <= 1'b0;
        flags_r   <= '0;
        count_r   <= '0;
        ovf_r     <= 1'b0;
      end
    end
  end

  // Payload registers; a survivor is emitted once the next one is known.
  always_ff @(posedge clk) begin
    if (cmd.lat_si) score_i_r <= score_q;
    if (cmd.lat_idx_i) idx_i_r <= rank_q;
    if (cmd.lat_idx_j) idx_j_r <= rank_q;
    if (cmd.lat_b) box_b_r <= box_q;
    if (cmd.lat_a || cmd.flush) begin
      out_kept_left       <= box_a_r[15:0];
      out_kept_top        <= box_a_r[31:16];
      out_kept_right      <= box_a_r[47:32];
      out_kept_bottom     <= box_a_r[63:48];
      out_kept_confidence <= score_a_r;
      out_overflowed      <= ovf_r;
      out_final_kept      <= cmd.flush;
    end
    if (cmd.lat_a) begin
      box_a_r   <= box_q;
      score_a_r <= score_q;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_BOXES))
    else $error("box count exceeds capacity");

  a_mark_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mark |-> !flags_r[idx_j_r])
    else $error("overlap test on an already suppressed box");

  a_final_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_final_kept) |=> !out_valid)
    else $error("result follows the last survivor of a batch");
`endif

endmodule

FILE: hw/rtl/box_non_maximum_suppression.sv
// ----------------------------------------------------------------------------
// box_non_maximum_suppression: greedy IoU non-maximum suppression
// Operation: a box is stored in its accept cycle; ranking compares each
// score with every score of the batch, then suppression checks each rank
// and sends every later live pair through the overlap pipeline.
// Throughput: one box per cycle while loading; the pairwise compare loop
// through the single-read box and score memories sets the batch time.
// Reset clears the sequencer, counters and flags; results cannot be stalled.
// ----------------------------------------------------------------------------
module box_non_maximum_suppression #(
  parameter int MAX_BOXES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel: one box per accepted beat.
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_left,
  input  logic signed [15:0] in_top,
  input  logic signed [15:0] in_right,
  input  logic signed [15:0] in_bottom,
  input  logic        [15:0] in_confidence,
  input  logic               in_final_box,
  // Result channel: one beat per surviving box, one cycle wide.
  output logic               out_valid,
  output logic signed [15:0] out_kept_left,
  output logic signed [15:0] out_kept_top,
  output logic signed [15:0] out_kept_right,
  output logic signed [15:0] out_kept_bottom,
  output logic        [15:0] out_kept_confidence,
  output logic               out_overflowed,
  output logic               out_final_kept,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [2:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);

  bnms_pkg::cmd_t  cmd;
  bnms_pkg::stat_t stat;

  // The threshold register is the only configuration state. Writes land on
  // the access phase; addresses past the register map are ignored.
  logic [15:0] iou_threshold_r;
  logic        reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == bnms_pkg::REG_IOU_THRESHOLD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iou_threshold_r <= bnms_pkg::IOU_THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      iou_threshold_r <= pwdata[15:0];
    end
  end

  assign prdata = reg_hit ? {16'h0000, iou_threshold_r} : 32'h0000_0000;

  // The sequencer walks loading, ranking and suppression; the datapath
  // holds the memories and does the arithmetic.
  bnms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .final_box (in_final_box),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  bnms_datapath #(.MAX_BOXES(MAX_BOXES)) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .iou_threshold       (iou_threshold_r),
    .in_left             (in_left),
    .in_top              (in_top),
    .in_right            (in_right),
    .in_bottom           (in_bottom),
    .in_confidence       (in_confidence),
    .out_valid           (out_valid),
    .out_kept_left       (out_kept_left),
    .out_kept_top        (out_kept_top),
    .out_kept_right      (out_kept_right),
    .out_kept_bottom     (out_kept_bottom),
    .out_kept_confidence (out_kept_confidence),
    .out_overflowed      (out_overflowed),
    .out_final_kept      (out_final_kept)
  );

endmodule

FILE: verif/box_non_maximum_suppression_tb.sv
// ----------------------------------------------------------------------------
// box_non_maximum_suppression_tb: self-checking bench for box NMS
// Loads batches of scored boxes through the input channel. Each batch is
// ranked and suppressed by a predictor inside the bench, and the survivors
// are checked beat by beat against the block's result strobes. The overlap
// threshold is reprogrammed between phases through the APB-style port.
// ----------------------------------------------------------------------------
module box_non_maximum_suppression_tb;

  localparam int CAPACITY   = 64;
  localparam int STALL_MAX  = 400000;  // cycles without any beat
  localparam int DRAIN_WAIT = 40;

  // One box as it enters the block.
  typedef struct {
    logic signed [15:0] lft;
    logic signed [15:0] tp;
    logic signed [15:0] rgt;
    logic signed [15:0] btm;
    logic        [15:0] conf;
  } box_t;

  // One surviving box as the block should emit it.
  typedef struct {
    box_t bx;
    logic ovf;
    logic last_kept;
  } kept_t;

  // The scoreboard keeps its own copy of the batch being loaded and of the
  // threshold. When the last box of a batch is accepted it runs the ranking
  // and greedy suppression and queues every survivor it expects.
  class nms_scoreboard;
    box_t        batch[CAPACITY];
    int          count;
    bit          overflow;
    logic [15:0] threshold;
    kept_t       survivors[$];
    int          errors;

    function new();
      count     = 0;
      overflow  = 0;
      threshold = bnms_pkg::IOU_THRESHOLD_RESET;
      errors    = 0;
    endfunction

    // Intersection over union above threshold, in exact integer terms.
    // A union that is zero or negative never counts as overlap.
    function bit too_close(box_t a, box_t b);
      longint iw, ih, inter, uni;
      iw = ((a.rgt < b.rgt) ? a.rgt : b.rgt) - ((a.lft > b.lft) ? a.lft : b.lft);
      ih = ((a.btm < b.btm) ? a.btm : b.btm) - ((a.tp > b.tp) ? a.tp : b.tp);
      if (iw < 0) iw = 0;
      if (ih < 0) ih = 0;
      inter = iw * ih;
      uni = (longint'(a.rgt) - longint'(a.lft)) * (longint'(a.btm) - longint'(a.tp))
          + (longint'(b.rgt) - longint'(b.lft)) * (longint'(b.btm) - longint'(b.tp))
          - inter;
      if (uni <= 0) return 0;
      return inter * 65536 > longint'(threshold) * uni;
    endfunction

    function void note_box(box_t bx, bit last_box);
      int    order[CAPACITY];
      bit    gone[CAPACITY];
      int    i, j, k, last_idx;
      kept_t kb;
      if (count < CAPACITY) begin
        batch[count] = bx;
        count++;
      end else begin
        overflow = 1;
      end
      if (!last_box) return;
      // Stable insertion sort on descending confidence.
      for (i = 0; i < count; i++) begin
        j = i;
        while (j > 0 && batch[order[j-1]].conf < batch[i].conf) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = i;
      end
      for (i = 0; i < count; i++) gone[i] = 0;
      last_idx = -1;
      for (i = 0; i < count; i++) begin
        if (gone[order[i]]) continue;
        kb.bx        = batch[order[i]];
        kb.ovf       = overflow;
        kb.last_kept = 0;
        survivors = {survivors, kb};
        last_idx = survivors.size() - 1;
        for (k = i + 1; k < count; k++)
          if (!gone[order[k]] && too_close(kb.bx, batch[order[k]]))
            gone[order[k]] = 1;
      end
      survivors[last_idx].last_kept = 1;
      count    = 0;
      overflow = 0;
    endfunction

    function void check_kept(kept_t got);
      kept_t want;
      if (survivors.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      want = survivors.pop_front();
      if (got.bx.lft !== want.bx.lft) begin
        $error("kept_left: expected %0d, got %0d", want.bx.lft, got.bx.lft);
        errors++;
      end
      if (got.bx.tp !== want.bx.tp) begin
        $error("kept_top: expected %0d, got %0d", want.bx.tp, got.bx.tp);
        errors++;
      end
      if (got.bx.rgt !== want.bx.rgt) begin
        $error("kept_right: expected %0d, got %0d", want.bx.rgt, got.bx.rgt);
        errors++;
      end
      if (got.bx.btm !== want.bx.btm) begin
        $error("kept_bottom: expected %0d, got %0d", want.bx.btm, got.bx.btm);
        errors++;
      end
      if (got.bx.conf !== want.bx.conf) begin
        $error("kept_confidence: expected %0d, got %0d", want.bx.conf, got.bx.conf);
        errors++;
      end
      if (got.ovf !== want.ovf) begin
        $error("overflowed: expected %0d, got %0d", want.ovf, got.ovf);
        errors++;
      end
      if (got.last_kept !== want.last_kept) begin
        $error("final_kept: expected %0d, got %0d", want.last_kept, got.last_kept);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst_n = 0;
  logic               start = 0;
  logic               busy;
  logic signed [15:0] in_left = 0, in_top = 0, in_right = 0, in_bottom = 0;
  logic        [15:0] in_confidence = 0;
  logic               in_final_box = 0;
  logic               out_valid;
  logic signed [15:0] out_kept_left, out_kept_top, out_kept_right, out_kept_bottom;
  logic        [15:0] out_kept_confidence;
  logic               out_overflowed, out_final_kept;
  logic               psel = 0, penable = 0, pwrite = 0;
  logic        [2:0]  paddr = 0;
  logic        [31:0] pwdata = 0;
  logic        [31:0] prdata;
  logic               pready;

  nms_scoreboard sb = new();
  int            idle_pct = 0;   // chance in percent that the sender skips a cycle
  int            quiet_cycles = 0;

  box_non_maximum_suppression #(.MAX_BOXES(CAPACITY)) uut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // Every result strobe is a beat that cannot be held off, so it is checked
  // at the edge that closes its cycle.
  always @(posedge clk) begin
    kept_t got;
    if (rst_n && out_valid) begin
      got.bx.lft    = out_kept_left;
      got.bx.tp     = out_kept_top;
      got.bx.rgt    = out_kept_right;
      got.bx.btm    = out_kept_bottom;
      got.bx.conf   = out_kept_confidence;
      got.ovf       = out_overflowed;
      got.last_kept = out_final_kept;
      sb.check_kept(got);
    end
  end

  // Watchdog: the run is hung if no beat moves for too long. The limit
  // covers a full batch of boxes that are all ranked and compared.
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_MAX) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Drives one box. Entered and left just after a falling edge; busy only
  // moves on rising edges, so its value here is what the next edge sees.
  task automatic send_box(box_t bx, bit last_box);
    while ($urandom_range(99) < idle_pct) begin
      start = 0;
      @(negedge clk);
    end
    start         = 1;
    in_left       = bx.lft;
    in_top        = bx.tp;
    in_right      = bx.rgt;
    in_bottom     = bx.btm;
    in_confidence = bx.conf;
    in_final_box  = last_box;
    while (busy) @(negedge clk);
    @(posedge clk);
    sb.note_box(bx, last_box);
    @(negedge clk);
  endtask

  // Waits until every expected survivor has arrived and the block is idle.
  task automatic drain();
    start = 0;
    while (sb.survivors.size() != 0 || busy) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // Writes the threshold in a setup and an access cycle, then reads it back.
  task automatic set_threshold(logic [15:0] value);
    paddr  = 3'(bnms_pkg::REG_IOU_THRESHOLD) << 2;
    pwdata = {16'd0, value};
    pwrite = 1;
    psel   = 1;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    pwrite  = 0;
    penable = 0;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    if (prdata[15:0] !== value) begin
      $error("iou_threshold readback: expected %0d, got %0d", value, prdata[15:0]);
      sb.errors++;
    end
    @(negedge clk);
    psel    = 0;
    penable = 0;
    sb.threshold = value;
  endtask

  function automatic box_t make_box(int lx, int ty, int w, int h, int c);
    box_t bx;
    bx.lft  = 16'(lx);
    bx.tp   = 16'(ty);
    bx.rgt  = 16'(lx + w);
    bx.btm  = 16'(ty + h);
    bx.conf = 16'(c);
    return bx;
  endfunction

  // Random box. Most boxes sit around a shared center so that they overlap;
  // a few span the full coordinate range, and a few are inverted.
  function automatic box_t rand_box(int cx, int cy);
    box_t bx;
    int   pick, c;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 30)
      c = 1000 * $urandom_range(3);   // repeated scores exercise tie order
    else
      c = $urandom_range(65535);
    if (pick < 75) begin
      bx = make_box(cx + $urandom_range(120) - 60, cy + $urandom_range(120) - 60,
                    $urandom_range(400), $urandom_range(400), c);
    end else begin
      bx.lft  = 16'($urandom_range(65535));
      bx.tp   = 16'($urandom_range(65535));
      bx.rgt  = 16'($urandom_range(65535));
      bx.btm  = 16'($urandom_range(65535));
      bx.conf = 16'(c);
      // Mostly well formed; otherwise the edges stay inverted as drawn.
      if (pick < 92) begin
        if (bx.rgt < bx.lft) {bx.lft, bx.rgt} = {bx.rgt, bx.lft};
        if (bx.btm < bx.tp) {bx.tp, bx.btm} = {bx.btm, bx.tp};
      end
    end
    return bx;
  endfunction

  task automatic rand_batch(int size);
    int cx, cy;
    cx = $urandom_range(60000) - 30000;
    cy = $urandom_range(60000) - 30000;
    for (int i = 0; i < size; i++) send_box(rand_box(cx, cy), i == size - 1);
  endtask

  task automatic rand_phase(int items);
    int sent, size;
    sent = 0;
    while (sent < items) begin
      size = ($urandom_range(19) == 0) ? $urandom_range(40, 20) : $urandom_range(8, 1);
      rand_batch(size);
      sent += size;
    end
    drain();
  endtask

  initial begin
    logic [15:0] thr_list[5];
    box_t        big;

    repeat (9) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Directed part at the reset threshold.
    big.lft = 16'sh8000; big.tp = 16'sh8000; big.rgt = 16'sh7fff; big.btm = 16'sh7fff;
    big.conf = 16'hffff;
    send_box(big, 1);                                       // full-range single box
    send_box(make_box(0, 0, 0, 0, 0), 1);                   // degenerate, zero score
    // Identical boxes with equal scores: the first loaded one survives.
    send_box(make_box(10, 10, 100, 100, 500), 0);
    send_box(make_box(10, 10, 100, 100, 500), 1);
    // Disjoint boxes both survive, listed by score.
    send_box(make_box(0, 0, 50, 50, 100), 0);
    send_box(make_box(500, 500, 50, 50, 900), 1);
    // Zero-area boxes give a zero union and never suppress.
    send_box(make_box(5, 5, 0, 0, 700), 0);
    send_box(make_box(5, 5, 0, 0, 600), 1);
    // Inverted boxes get negative sides and a clamped intersection.
    send_box(make_box(100, 100, -80, -80, 300), 0);
    send_box(make_box(30, 30, 50, 50, 800), 0);
    send_box(make_box(35, 35, 50, 50, 200), 1);
    // Partial overlaps around the default threshold.
    send_box(make_box(0, 0, 100, 100, 40000), 0);
    send_box(make_box(30, 0, 100, 100, 30000), 0);
    send_box(make_box(70, 0, 100, 100, 20000), 1);
    drain();

    // Extreme thresholds on overlapping batches, then an overflowing batch
    // whose final box is itself dropped.
    set_threshold(16'd0);
    rand_batch(6);
    drain();
    set_threshold(16'hffff);
    rand_batch(6);
    drain();
    for (int i = 0; i < CAPACITY + 3; i++)
      send_box(rand_box(0, 0), i == CAPACITY + 2);
    drain();

    thr_list = '{bnms_pkg::IOU_THRESHOLD_RESET, 16'd32768, 16'($urandom_range(65535)),
                 16'd0, 16'hffff};
    idle_pct = 13;
    set_threshold(thr_list[0]);
    rand_phase(100);
    set_threshold(thr_list[1]);
    rand_phase(80);
    idle_pct = 68;
    set_threshold(thr_list[2]);
    rand_phase(80);
    idle_pct = 0;
    set_threshold(thr_list[3]);
    rand_phase(70);
    set_threshold(thr_list[4]);
    rand_phase(60);

    if (sb.errors == 0 && sb.survivors.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (sb.survivors.size() != 0)
        $error("%0d expected survivors never arrived", sb.survivors.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
